// ----- sv/set_assoc_cache_tag_sim_macros.svh -----
// assertion macros for the cache tag model checker
`ifndef SET_ASSOC_CACHE_TAG_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_SIM_MACROS_SVH

// checked while out of reset
`define SACT_CHECK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sact check failed");

// checked at every edge, reset included
`define SACT_CHECK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sact check failed");

`endif

// ----- sv/sact_pkg.sv -----
// types, register codes and helpers shared by the cache tag model
`timescale 1ns / 1ps
`default_nettype none
package sact_pkg;

    localparam logic [2:0] REG_REPL   = 3'd0;
    localparam logic [2:0] REG_WPOL   = 3'd1;
    localparam logic [2:0] REG_OFFSET = 3'd2;
    localparam logic [2:0] REG_SETS   = 3'd3;
    localparam logic [2:0] REG_WAYS   = 3'd4;

    localparam logic [1:0] REPL_LRU    = 2'd0;
    localparam logic [1:0] REPL_FIFO   = 2'd1;
    localparam logic [1:0] REPL_RANDOM = 2'd2;
    localparam logic [1:0] REPL_RSVD   = 2'd3;

    localparam logic WPOL_WB = 1'b0;
    localparam logic WPOL_WT = 1'b1;

    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0]  MAX_OFFSET = 4'd12;
    localparam logic [2:0]  MAX_SET    = 3'd6;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] address;
    } t_item;

    typedef struct packed {
        logic [5:0]  set_sel;
        logic [31:0] tag;
        logic        hit;
    } t_result;

    typedef struct packed {
        logic [1:0] repl;
        logic       wpol;
        logic [3:0] blk_shift;
        logic [2:0] idx_bits;
        logic [3:0] ways_used;
    } t_cfg;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  set_sel;
        logic [31:0] tag;
    } t_job;

    function automatic logic [15:0] lfsr_next(input logic [15:0] x);
        logic fb;
        fb = x[0] ^ x[2] ^ x[3] ^ x[5];
        return {fb, x[15:1]};
    endfunction

endpackage
`default_nettype wire

// ----- sv/set_assoc_cache_tag_sim.sv -----
// top level of the set-associative cache tag model
// channel   | handshake                       | payload
// input     | i_start, o_busy                 | i_item (cmd, address)
// result    | o_valid strobe, one cycle       | o_result (set_sel, tag, hit)
// config    | psel, penable, pwrite, pready   | paddr, pwdata, prdata
// an access in the back end is one ram read of the set row, then one evaluate
// and write-back step; a random eviction adds a bit-serial remainder pass over
// the 16 lfsr bits. a two-entry queue sits ahead of the back end, o_busy is
// high when it is full. synchronous active-low reset clears the counter and
// seeds the lfsr, then a clearing pass over all NUM_SETS rows zeroes the valid
// bits before the back end takes its first job. results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_tag_sim #(
    parameter int NUM_SETS = 64,
    parameter int NUM_WAYS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire sact_pkg::t_item   i_item,
    output logic                   o_busy,
    output logic                   o_valid,
    output sact_pkg::t_result      o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    sact_pkg::t_cfg r_cfg;
    sact_pkg::t_job head;
    logic empty, pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repl      <= sact_pkg::REPL_LRU;
            r_cfg.wpol      <= sact_pkg::WPOL_WB;
            r_cfg.blk_shift <= 4'd6;
            r_cfg.idx_bits  <= 3'd6;
            r_cfg.ways_used <= 4'd8;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                sact_pkg::REG_REPL:   r_cfg.repl      <= pwdata[1:0];
                sact_pkg::REG_WPOL:   r_cfg.wpol      <= pwdata[0];
                sact_pkg::REG_OFFSET: r_cfg.blk_shift <= pwdata[3:0];
                sact_pkg::REG_SETS:   r_cfg.idx_bits  <= pwdata[2:0];
                sact_pkg::REG_WAYS:   r_cfg.ways_used <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            sact_pkg::REG_REPL:   prdata = {30'd0, r_cfg.repl};
            sact_pkg::REG_WPOL:   prdata = {31'd0, r_cfg.wpol};
            sact_pkg::REG_OFFSET: prdata = {28'd0, r_cfg.blk_shift};
            sact_pkg::REG_SETS:   prdata = {29'd0, r_cfg.idx_bits};
            sact_pkg::REG_WAYS:   prdata = {28'd0, r_cfg.ways_used};
            default:              prdata = 32'd0;
        endcase
    end

    sact_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .i_cfg(r_cfg), .i_pop(pop), .o_head(head), .o_empty(empty));

    sact_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_empty(empty),
        .i_head(head), .o_pop(pop), .o_valid(o_valid), .o_result(o_result));
endmodule
`default_nettype wire

// ----- sv/sact_ram.sv -----
// generic single-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module sact_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- sv/sact_front.sv -----
// address split and two-entry job queue
`timescale 1ns / 1ps
`default_nettype none
module sact_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire sact_pkg::t_item i_item,
    input  wire sact_pkg::t_cfg  i_cfg,
    input  wire logic          i_pop,
    output sact_pkg::t_job     o_head,
    output logic               o_empty
);
    sact_pkg::t_job r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [3:0] ob;
    logic [2:0] sb;
    logic [4:0] sh;
    logic [31:0] shifted;
    logic [6:0] mask;
    sact_pkg::t_job job;
    logic push, pop;

    always_comb begin
        ob = (i_cfg.blk_shift > sact_pkg::MAX_OFFSET) ? sact_pkg::MAX_OFFSET
                                                      : i_cfg.blk_shift;
        sb = (i_cfg.idx_bits > sact_pkg::MAX_SET) ? sact_pkg::MAX_SET : i_cfg.idx_bits;
        sh = {1'b0, ob} + {2'b0, sb};
        shifted = i_item.address >> ob;
        mask = (7'd1 << sb) - 7'd1;
        job.cmd = i_item.cmd;
        job.set_sel = shifted[5:0] & mask[5:0];
        job.tag = i_item.address >> sh;
    end

    assign o_busy  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_q[r_rp];
    assign push    = i_start && !o_busy;
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= job;
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- sv/sact_back.sv -----
// set lookup, victim choice and line update
`timescale 1ns / 1ps
`default_nettype none
module sact_back #(
    parameter int NUM_SETS = 64,
    parameter int NUM_WAYS = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sact_pkg::t_cfg  i_cfg,
    input  wire logic            i_empty,
    input  wire sact_pkg::t_job  i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    output sact_pkg::t_result    o_result
);
    localparam int RW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WIW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CW  = $clog2(NUM_WAYS + 1);
    localparam int RAMW = NUM_WAYS * 32;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_MOD, S_CLR} t_state;

    t_state r_state;
    sact_pkg::t_job r_cur;
    logic [RW-1:0] r_row;
    logic [RW-1:0] r_clr;
    logic [31:0] r_count;
    logic [15:0] r_lfsr, r_x;
    logic [CW-1:0] r_rem;
    logic [3:0] r_bit;

    logic [RAMW-1:0] tag_rd, use_rd, fill_rd, tag_wd, use_wd, fill_wd;
    logic [NUM_WAYS-1:0] vld_rd, vld_wd;
    logic vld_we;
    logic [RW-1:0] vld_waddr;
    logic [RW-1:0] rd_row;
    logic we;
    logic [CW-1:0] ways;
    logic [NUM_WAYS-1:0] vrow;
    logic hit, empty_found, alloc, go_mod, fill;
    logic [WIW-1:0] hit_w, empty_w, min_w, wr_way;
    logic [31:0] best, stamp, cnt_n;
    logic [CW:0] t_rem;
    logic [CW-1:0] rem_n;
    logic [15:0] lfsr_n;
    logic [$bits(int)-1:0] ways_i;

    // row of each set index, folded onto the stored rows
    always_comb begin
        rd_row = '0;
        for (int s = 0; s < 64; s++) begin
            if (i_head.set_sel == 6'(s)) begin
                rd_row = RW'(s % NUM_SETS);
            end
        end
    end

    assign o_pop  = (r_state == S_IDLE) && !i_empty;

    sact_ram #(.WIDTH(RAMW), .DEPTH(NUM_SETS)) u_tag (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_row), .i_wdata(tag_wd),
        .i_re(o_pop), .i_raddr(rd_row), .o_rdata(tag_rd));
    sact_ram #(.WIDTH(RAMW), .DEPTH(NUM_SETS)) u_use (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_row), .i_wdata(use_wd),
        .i_re(o_pop), .i_raddr(rd_row), .o_rdata(use_rd));
    sact_ram #(.WIDTH(RAMW), .DEPTH(NUM_SETS)) u_fill (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_row), .i_wdata(fill_wd),
        .i_re(o_pop), .i_raddr(rd_row), .o_rdata(fill_rd));
    sact_ram #(.WIDTH(NUM_WAYS), .DEPTH(NUM_SETS)) u_vld (
        .i_clk(i_clk), .i_we(vld_we), .i_waddr(vld_waddr), .i_wdata(vld_wd),
        .i_re(o_pop), .i_raddr(rd_row), .o_rdata(vld_rd));

    always_comb begin
        ways_i = (i_cfg.ways_used == 4'd0) ? 1 : int'(i_cfg.ways_used);
        if (ways_i > NUM_WAYS) begin
            ways_i = NUM_WAYS;
        end
        ways = CW'(ways_i);
        vrow = vld_rd;
        cnt_n = r_count + 32'd1;
        hit = 1'b0;
        hit_w = '0;
        empty_found = 1'b0;
        empty_w = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w < ways_i && !hit && vrow[w] && tag_rd[w*32 +: 32] == r_cur.tag) begin
                hit = 1'b1;
                hit_w = WIW'(w);
            end
            if (w < ways_i && !empty_found && !vrow[w]) begin
                empty_found = 1'b1;
                empty_w = WIW'(w);
            end
        end
        best = (i_cfg.repl == sact_pkg::REPL_FIFO) ? fill_rd[31:0] : use_rd[31:0];
        min_w = '0;
        for (int w = 1; w < NUM_WAYS; w++) begin
            if (w < ways_i) begin
                if (i_cfg.repl == sact_pkg::REPL_FIFO) begin
                    if (fill_rd[w*32 +: 32] < best) begin
                        best = fill_rd[w*32 +: 32];
                        min_w = WIW'(w);
                    end
                end else if (use_rd[w*32 +: 32] < best) begin
                    best = use_rd[w*32 +: 32];
                    min_w = WIW'(w);
                end
            end
        end
        alloc = !(r_cur.cmd == sact_pkg::CMD_WRITE && i_cfg.wpol == sact_pkg::WPOL_WT);
        go_mod = !hit && alloc && !empty_found && (i_cfg.repl == sact_pkg::REPL_RANDOM);
        lfsr_n = sact_pkg::lfsr_next(r_lfsr);

        t_rem = {r_rem, r_x[r_bit]};
        if (t_rem >= {1'b0, ways}) begin
            t_rem = t_rem - {1'b0, ways};
        end
        rem_n = t_rem[CW-1:0];

        we = 1'b0;
        fill = 1'b0;
        wr_way = '0;
        stamp = cnt_n;
        if (r_state == S_EVAL) begin
            if (hit) begin
                we = 1'b1;
                wr_way = hit_w;
            end else if (alloc && !go_mod) begin
                we = 1'b1;
                fill = 1'b1;
                wr_way = empty_found ? empty_w : min_w;
            end
        end else if (r_state == S_MOD && r_bit == 4'd0) begin
            we = 1'b1;
            fill = 1'b1;
            wr_way = WIW'(rem_n);
            stamp = r_count;
        end
        tag_wd = tag_rd;
        use_wd = use_rd;
        fill_wd = fill_rd;
        use_wd[wr_way*32 +: 32] = stamp;
        if (fill) begin
            tag_wd[wr_way*32 +: 32] = r_cur.tag;
            fill_wd[wr_way*32 +: 32] = stamp;
        end

        vld_we = we;
        vld_waddr = r_row;
        vld_wd = vrow;
        if (fill) begin
            vld_wd[wr_way] = 1'b1;
        end
        if (r_state == S_CLR) begin
            vld_we = 1'b1;
            vld_waddr = r_clr;
            vld_wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_count <= '0;
            r_lfsr  <= sact_pkg::LFSR_SEED;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + RW'(1);
                    if (r_clr == RW'(NUM_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cur   <= i_head;
                        r_row   <= rd_row;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_count <= cnt_n;
                    o_result.set_sel <= r_cur.set_sel;
                    o_result.tag <= r_cur.tag;
                    o_result.hit <= hit;
                    if (go_mod) begin
                        r_lfsr  <= lfsr_n;
                        r_x     <= lfsr_n;
                        r_rem   <= '0;
                        r_bit   <= 4'd15;
                        r_state <= S_MOD;
                    end else begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_MOD: begin
                    r_rem <= rem_n;
                    r_bit <= r_bit - 4'd1;
                    if (r_bit == 4'd0) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/sact_checker.sv -----
// port-level checks for the cache tag model, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_tag_sim_macros.svh"
module sact_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_busy,
    input wire logic              o_valid,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pready
);
    `SACT_CHECK(a_no_back_to_back_results, i_clk, i_rst_n, o_valid |=> !o_valid)
    `SACT_CHECK_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid && !o_busy)
    `SACT_CHECK(a_first_result_gap, i_clk, i_rst_n, $rose(i_rst_n) |-> !o_valid)
    `SACT_CHECK(a_ready_high, i_clk, i_rst_n, psel && penable |-> pready)
endmodule

bind set_assoc_cache_tag_sim sact_checker u_sact_checker (.*);
`default_nettype wire
